/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/lcabl_pkg.sv */
`default_nettype none

package lcabl_pkg;

  localparam int NODE_W = 10;
  localparam int NODES  = 1 << NODE_W;
  localparam int LEVELS = 10;
  localparam int LVL_W  = $clog2(LEVELS);

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [LVL_W-1:0]  lvl_t;

  // One table row per node: its depth and its ancestors 2^level steps up.
  typedef struct packed {
    node_t                  depth;
    node_t [LEVELS-1:0]     jump;
  } row_t;

  // Access request from the sequencer to the table.
  typedef struct packed {
    logic  rd_en;
    node_t rd_addr;
    logic  wr_en;
    node_t wr_addr;
  } tbl_req_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

endpackage

`default_nettype wire

/* rtl/core/lca_binary_lifting.sv */
// Lowest common ancestor engine built on a binary lifting table.
// Input channel (in_valid/in_ready) carries in_operation, in_node_a and in_node_b.
// An insert item places node_a under parent node_b; the parent must have been
// inserted before, and node 0 is the sentinel above every root. An insert gives no
// result. A query item gives exactly one result item on the output channel
// (out_valid/out_ready) holding the lowest common ancestor of the two nodes.
// After reset the block sweeps all 1024 rows of its table clear, one row per cycle;
// in_ready stays low during that sweep.
// The block works on one item at a time. Every step of the walk is a read of the
// table memory, whose registered read data arrives in the next cycle, so the table
// port sets the pace: an insert reads its parent's row, then one row per higher
// level, and writes its own row before the next item is taken. A query reads the
// rows of both nodes, lifts the deeper one level by level (one read per lift),
// and, unless the nodes already meet, climbs both (two reads per climbing step)
// before it presents its result.
// The result sits in an output register. While the receiver stalls, the block still
// accepts and processes further inserts; a query that finishes waits until the
// pending result has been taken.
`default_nettype none

`include "assert_macros.svh"

module lca_binary_lifting (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [9:0]            in_node_a,
  input  logic [9:0]            in_node_b,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [9:0]            out_ancestor
);
  import lcabl_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_I_RD    = 4'd1;
  localparam logic [3:0] S_I_PAR   = 4'd2;
  localparam logic [3:0] S_I_MID   = 4'd3;
  localparam logic [3:0] S_I_WR    = 4'd4;
  localparam logic [3:0] S_Q_RDA   = 4'd5;
  localparam logic [3:0] S_Q_RDB   = 4'd6;
  localparam logic [3:0] S_Q_SWP   = 4'd7;
  localparam logic [3:0] S_Q_LIFT  = 4'd8;
  localparam logic [3:0] S_Q_LWAIT = 4'd9;
  localparam logic [3:0] S_Q_CMP   = 4'd10;
  localparam logic [3:0] S_Q_CLIMB = 4'd11;
  localparam logic [3:0] S_Q_CWU   = 4'd12;
  localparam logic [3:0] S_Q_CWV   = 4'd13;
  localparam logic [3:0] S_Q_OUT   = 4'd14;

  logic [3:0] state_r, state_nxt;
  node_t      a_r, a_nxt;
  node_t      b_r, b_nxt;
  node_t      u_r, u_nxt;
  node_t      v_r, v_nxt;
  row_t       row_u_r, row_u_nxt;
  row_t       row_v_r, row_v_nxt;
  lvl_t       lvl_r, lvl_nxt;
  logic       out_valid_r, out_valid_nxt;
  node_t      out_ancestor_r, out_ancestor_nxt;

  tbl_req_t   req;
  row_t       rd_row;
  logic       tbl_busy;

  lvl_t       lvl_m1;
  node_t      mid;
  node_t      ins_val;
  node_t      par_depth;
  node_t      depth_diff;
  logic       lift;
  node_t      ju;
  node_t      jv;
  logic       in_fire;

  lcabl_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .wr_row (row_u_r),
    .rd_row (rd_row),
    .busy   (tbl_busy)
  );

  assign in_ready = (state_r == S_IDLE) && !tbl_busy;
  assign in_fire  = in_valid && in_ready;

  // Insert: the ancestor at level L is the level L-1 ancestor of the level L-1
  // ancestor. When that middle node is the node being inserted, its fresh row
  // is still in row_u_r and has not reached the memory yet, so it is forwarded.
  assign lvl_m1    = lvl_r - lvl_t'(1);
  assign mid       = row_u_r.jump[lvl_m1];
  assign ins_val   = (mid == a_r) ? mid : rd_row.jump[lvl_m1];
  assign par_depth = rd_row.depth;

  // Query: lift u while the depth gap still covers 2^level. The depth of u is
  // always taken from its own row, just as stored.
  assign depth_diff = row_u_r.depth - row_v_r.depth;
  assign lift       = (row_u_r.depth >= row_v_r.depth) && ((depth_diff >> lvl_r) != '0);
  assign ju         = row_u_r.jump[lvl_r];
  assign jv         = row_v_r.jump[lvl_r];

  always_comb begin
    state_nxt        = state_r;
    a_nxt            = a_r;
    b_nxt            = b_r;
    u_nxt            = u_r;
    v_nxt            = v_r;
    row_u_nxt        = row_u_r;
    row_v_nxt        = row_v_r;
    lvl_nxt          = lvl_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_ancestor_nxt = out_ancestor_r;
    req              = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          a_nxt = in_node_a;
          b_nxt = in_node_b;
          if (in_operation == OP_QUERY) begin
            state_nxt = S_Q_RDA;
          end else if (in_node_a != '0) begin
            state_nxt = S_I_RD;
          end
        end
      end

      S_I_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = b_r;
        state_nxt   = S_I_PAR;
      end

      S_I_PAR: begin
        // The parent row gives the depth and, directly, the level one ancestor.
        row_u_nxt         = '0;
        row_u_nxt.depth   = (par_depth == '1) ? par_depth : par_depth + 1'b1;
        row_u_nxt.jump[0] = b_r;
        row_u_nxt.jump[1] = (b_r == a_r) ? b_r : rd_row.jump[0];
        if (LEVELS == 2) begin
          state_nxt = S_I_WR;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = row_u_nxt.jump[1];
          lvl_nxt     = lvl_t'(2);
          state_nxt   = S_I_MID;
        end
      end

      S_I_MID: begin
        row_u_nxt.jump[lvl_r] = ins_val;
        if (lvl_r == lvl_t'(LEVELS - 1)) begin
          state_nxt = S_I_WR;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = ins_val;
          lvl_nxt     = lvl_r + lvl_t'(1);
        end
      end

      S_I_WR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = a_r;
        state_nxt   = S_IDLE;
      end

      S_Q_RDA: begin
        req.rd_en   = 1'b1;
        req.rd_addr = a_r;
        state_nxt   = S_Q_RDB;
      end

      S_Q_RDB: begin
        req.rd_en   = 1'b1;
        req.rd_addr = b_r;
        row_u_nxt   = rd_row;
        state_nxt   = S_Q_SWP;
      end

      S_Q_SWP: begin
        // Make u the deeper node; row_u_r holds the row of node a here.
        if (row_u_r.depth < rd_row.depth) begin
          u_nxt     = b_r;
          v_nxt     = a_r;
          row_u_nxt = rd_row;
          row_v_nxt = row_u_r;
        end else begin
          u_nxt     = a_r;
          v_nxt     = b_r;
          row_v_nxt = rd_row;
        end
        lvl_nxt   = lvl_t'(LEVELS - 1);
        state_nxt = S_Q_LIFT;
      end

      S_Q_LIFT: begin
        if (lift) begin
          u_nxt       = ju;
          req.rd_en   = 1'b1;
          req.rd_addr = ju;
          state_nxt   = S_Q_LWAIT;
        end else if (lvl_r == '0) begin
          state_nxt = S_Q_CMP;
        end else begin
          lvl_nxt = lvl_m1;
        end
      end

      S_Q_LWAIT: begin
        row_u_nxt = rd_row;
        if (lvl_r == '0) begin
          state_nxt = S_Q_CMP;
        end else begin
          lvl_nxt   = lvl_m1;
          state_nxt = S_Q_LIFT;
        end
      end

      S_Q_CMP: begin
        if (u_r == v_r) begin
          state_nxt = S_Q_OUT;
        end else begin
          lvl_nxt   = lvl_t'(LEVELS - 1);
          state_nxt = S_Q_CLIMB;
        end
      end

      S_Q_CLIMB: begin
        if (ju != jv) begin
          u_nxt       = ju;
          v_nxt       = jv;
          req.rd_en   = 1'b1;
          req.rd_addr = ju;
          state_nxt   = S_Q_CWU;
        end else if (lvl_r == '0) begin
          state_nxt = S_Q_OUT;
        end else begin
          lvl_nxt = lvl_m1;
        end
      end

      S_Q_CWU: begin
        row_u_nxt   = rd_row;
        req.rd_en   = 1'b1;
        req.rd_addr = v_r;
        state_nxt   = S_Q_CWV;
      end

      S_Q_CWV: begin
        row_v_nxt = rd_row;
        if (lvl_r == '0) begin
          state_nxt = S_Q_OUT;
        end else begin
          lvl_nxt   = lvl_m1;
          state_nxt = S_Q_CLIMB;
        end
      end

      S_Q_OUT: begin
        // After climbing, u and v always differ and their common parent is the
        // answer; if lifting already met, u itself is the answer.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_ancestor_nxt = (u_r == v_r) ? u_r : row_u_r.jump[0];
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lvl_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lvl_r       <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r            <= a_nxt;
    b_r            <= b_nxt;
    u_r            <= u_nxt;
    v_r            <= v_nxt;
    row_u_r        <= row_u_nxt;
    row_v_r        <= row_v_nxt;
    out_ancestor_r <= out_ancestor_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_ancestor = out_ancestor_r;

  // The sequencer never reads and writes the table in the same cycle.
  `ASSERT_IMPLIES(a_no_rd_wr_overlap, clk, rst_n, req.wr_en, !req.rd_en)
  // The sentinel row is never rewritten.
  `ASSERT_IMPLIES(a_no_sentinel_write, clk, rst_n, req.wr_en, req.wr_addr != '0)
  // A result appears only out of the final query step.
  `ASSERT_IMPLIES(a_result_from_query, clk, rst_n, $rose(out_valid_r),
                  $past(state_r) == S_Q_OUT)
  // The level counter stays within the table.
  `ASSERT_IMPLIES(a_level_range, clk, rst_n, 1'b1, lvl_r <= lvl_t'(LEVELS - 1))
  // An accepted query always starts its walk in the next cycle.
  `ASSERT_NEXT(a_query_starts, clk, rst_n, in_fire && (in_operation == OP_QUERY),
               state_r == S_Q_RDA)

endmodule

`default_nettype wire

/* rtl/core/lcabl_table.sv */
`default_nettype none

module lcabl_table (
  input  logic               clk,
  input  logic               rst_n,
  input  lcabl_pkg::tbl_req_t req,
  input  lcabl_pkg::row_t    wr_row,
  output lcabl_pkg::row_t    rd_row,
  output logic               busy
);
  import lcabl_pkg::*;

  row_t  mem [NODES];
  row_t  rd_row_r;
  node_t clr_idx_r;
  logic  clr_busy_r;

  // After reset every row is cleared, one per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == node_t'(NODES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= wr_row;
    end
    if (req.rd_en) begin
      rd_row_r <= mem[req.rd_addr];
    end
  end

  assign rd_row = rd_row_r;
  assign busy   = clr_busy_r;

endmodule

`default_nettype wire

/* verif/lca_binary_lifting_tb.sv */
`default_nettype none

module lca_binary_lifting_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcabl_pkg::*;

  // Cycles in which neither channel moves an item before the run is declared
  // hung. The slowest legal quiet stretches are the clearing sweep after reset
  // and a long receiver hold followed by one query that fires every step.
  localparam int IDLE_LIMIT  = 4000;
  // Cycles allowed after the last expected result before the next phase. An
  // insert gives no result, so the block may still be writing the table.
  localparam int DRAIN_TAIL  = 64;
  localparam int LONG_HOLD   = 500;
  localparam int TREE_ITEMS  = 120;
  localparam int CHAIN_LEN   = 520;
  localparam int CHAIN_PROBE = 60;

  typedef struct packed {
    logic  op;
    node_t a;
    node_t b;
  } lca_item_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic        in_operation = OP_INSERT;
  logic [9:0]  in_node_a    = '0;
  logic [9:0]  in_node_b    = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [9:0]  out_ancestor;

  lca_binary_lifting dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_node_a    (in_node_a),
    .in_node_b    (in_node_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_ancestor (out_ancestor)
  );

  always #2 clk = ~clk;

  // The testbench's own copy of the tree: depth of every node and, per level,
  // the ancestor 2^level steps up. Both start all zero, as after reset.
  node_t anc_table [NODES][LEVELS];
  node_t depth_of  [NODES];

  lca_item_t pending_items[$];
  node_t     expected_ancestors[$];

  // Generator-side bookkeeping of which nodes have been placed in a tree, so
  // that most queries name real nodes and most inserts name a real parent.
  bit    placed_map [NODES];
  node_t placed_list[$];

  int errors       = 0;
  int results_seen = 0;
  int idle_cycles  = 0;

  task automatic report_mismatch(string what, logic [9:0] got, node_t want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Insert rule: depth is one more than the parent's and saturates at the
  // largest node number. Level 0 is the parent, and each higher level is two
  // hops of the level below. Inserting the sentinel changes nothing.
  function automatic void tree_insert(node_t n, node_t p);
    int d;
    if (n == '0) return;
    d = int'(depth_of[p]) + 1;
    if (d > NODES - 1) d = NODES - 1;
    depth_of[n] = node_t'(d);
    anc_table[n][0] = p;
    for (int l = 1; l < LEVELS; l++) anc_table[n][l] = anc_table[anc_table[n][l-1]][l-1];
  endfunction

  // Lift the deeper node by the depth gap, one power of two at a time, then
  // climb both while their ancestors differ. If the lift lands on the other
  // node, that node is the answer.
  function automatic node_t predict_lca(node_t a, node_t b);
    node_t u;
    node_t v;
    node_t t;
    u = a;
    v = b;
    if (depth_of[u] < depth_of[v]) begin
      t = u;
      u = v;
      v = t;
    end
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (int'(depth_of[u]) >= int'(depth_of[v]) &&
          int'(depth_of[u]) - int'(depth_of[v]) >= (1 << l))
        u = anc_table[u][l];
    end
    if (u == v) return u;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (anc_table[u][l] != anc_table[v][l]) begin
        u = anc_table[u][l];
        v = anc_table[v][l];
      end
    end
    return anc_table[u][0];
  endfunction

  // Called once per accepted item, in acceptance order, which is the order in
  // which the block applies them.
  function automatic void track_accepted_item(lca_item_t it);
    if (it.op == OP_QUERY) expected_ancestors.push_back(predict_lca(it.a, it.b));
    else tree_insert(it.a, it.b);
  endfunction

  task automatic push_insert(node_t n, node_t p);
    pending_items.push_back('{op: OP_INSERT, a: n, b: p});
    if (n != '0 && !placed_map[n]) begin
      placed_map[n] = 1'b1;
      placed_list.push_back(n);
    end
  endtask

  task automatic push_query(node_t a, node_t b);
    pending_items.push_back('{op: OP_QUERY, a: a, b: b});
  endtask

  function automatic node_t any_node();
    return node_t'($urandom_range(0, NODES - 1));
  endfunction

  function automatic node_t pick_placed();
    if (placed_list.size() == 0) return '0;
    return placed_list[$urandom_range(0, placed_list.size() - 1)];
  endfunction

  // A node number not yet in any tree, if one turns up within a few tries.
  function automatic node_t fresh_node();
    node_t n;
    n = node_t'($urandom_range(1, NODES - 1));
    for (int i = 0; i < 20 && placed_map[n]; i++) n = node_t'($urandom_range(1, NODES - 1));
    return n;
  endfunction

  // Mostly well-formed traffic: new nodes under placed parents and queries on
  // placed nodes. About one item in ten is noise: unplaced nodes, the
  // sentinel, a parent that was never inserted, or a reinsertion.
  task automatic gen_tree_items(int count);
    int roll;
    node_t n;
    node_t p;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        n = fresh_node();
        if (placed_list.size() == 0 || $urandom_range(0, 9) == 0) p = '0;
        else p = pick_placed();
        push_insert(n, p);
      end else if (roll < 90) begin
        if ($urandom_range(0, 19) == 0) push_query(pick_placed(), '0);
        else push_query(pick_placed(), pick_placed());
      end else begin
        case ($urandom_range(0, 3))
          0: push_query(any_node(), any_node());
          1: push_insert('0, any_node());
          2: push_insert(fresh_node(), any_node());
          default: push_insert(pick_placed(), pick_placed());
        endcase
      end
    end
  endtask

  // Holds the sender back until every queued item is in, every result is out
  // and the block has had time to finish a trailing insert.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_ancestors.size() != 0)
      @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Sender. Items go out in bursts of random length separated by random gaps;
  // a gap of zero joins two bursts into a longer stretch without idling.
  // Valid is written once per edge, so an item that follows directly on the
  // one just accepted keeps valid high.
  lca_item_t cur_item;
  int        burst_left;
  int        gap_left;

  always @(posedge clk) begin
    bit offering;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = $urandom_range(1, 16);
      gap_left   = 0;
    end else begin
      offering = in_valid;
      if (in_valid && in_ready) begin
        track_accepted_item(cur_item);
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_operation <= cur_item.op;
          in_node_a    <= cur_item.a;
          in_node_b    <= cur_item.b;
          offering     = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end
        end
      end
      in_valid <= offering;
    end
  end

  // Receiver and checker. Ready follows a pattern that is redrawn whenever
  // its mode counter wraps: always ready, coin flip, a one-in-four chance,
  // or a fixed toggle. Twice in the run it holds off for a long stretch so
  // the output register stays full and the block has to stall its input.
  int ready_mode;
  int mode_cycles;
  int hold_left;
  int ready_tick;

  always @(posedge clk) begin
    node_t want;
    bit    next_ready;
    if (!rst_n) begin
      out_ready   <= 1'b0;
      ready_mode  = 0;
      mode_cycles = 0;
      hold_left   = 0;
      ready_tick  = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_ancestors.size() == 0) begin
          report_mismatch("result with no query waiting", out_ancestor, '0);
        end else begin
          want = expected_ancestors.pop_front();
          if (out_ancestor !== want) report_mismatch("ancestor", out_ancestor, want);
        end
        results_seen++;
        if (results_seen == 40 || results_seen == 80) hold_left = LONG_HOLD;
      end
      mode_cycles++;
      ready_tick++;
      if (mode_cycles >= 50) begin
        mode_cycles = 0;
        ready_mode  = $urandom_range(0, 3);
      end
      case (ready_mode)
        0:       next_ready = 1'b1;
        1:       next_ready = $urandom_range(0, 1);
        2:       next_ready = ($urandom_range(0, 3) == 0);
        default: next_ready = ready_tick[2];
      endcase
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end
      out_ready <= next_ready;
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    node_t chain [NODES-1];
    node_t t;
    int    j;
    int    i0;
    int    i1;

    for (int n = 0; n < NODES; n++) begin
      depth_of[n]   = '0;
      placed_map[n] = 1'b0;
      for (int l = 0; l < LEVELS; l++) anc_table[n][l] = '0;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Queries on an empty table, a small tree with the extreme
    // node numbers, the sentinel on either side of a query, an insert of the
    // sentinel, a parent that was never inserted (a second root), two trees
    // with nothing in common, and a reinsertion that leaves a stale child.
    push_query(10'd0, 10'd0);
    push_query(10'd1023, 10'd1023);
    push_insert(10'd1, 10'd0);
    push_insert(10'd2, 10'd1);
    push_insert(10'd1023, 10'd2);
    push_insert(10'd3, 10'd1);
    push_insert(10'd4, 10'd3);
    push_query(10'd1023, 10'd4);
    push_query(10'd4, 10'd1023);
    push_query(10'd1023, 10'd1023);
    push_query(10'd1023, 10'd0);
    push_query(10'd0, 10'd4);
    push_query(10'd2, 10'd1023);
    push_insert(10'd0, 10'd4);
    push_query(10'd0, 10'd1);
    push_insert(10'd5, 10'd700);
    push_query(10'd5, 10'd4);
    push_insert(10'd3, 10'd2);
    push_query(10'd4, 10'd3);
    push_query(10'd1023, 10'd3);
    push_insert(10'd682, 10'd1023);
    push_insert(10'd341, 10'd682);
    push_query(10'd341, 10'd4);
    push_query(10'd341, 10'd1023);
    wait_drained();

    // Random trees, with a full pause in the middle. The long receiver holds
    // fall in this stretch while the sender keeps offering.
    gen_tree_items(TREE_ITEMS);
    wait_drained();
    gen_tree_items(TREE_ITEMS);
    wait_drained();

    // One chain through CHAIN_LEN nodes taken in shuffled order. Its depths run
    // past 512, so queries on it fire every lifting level and the deep climbs.
    // Reinserting the deepest node under itself then points all of its levels
    // at itself and pushes its depth one further each time.
    for (int k = 0; k < NODES - 1; k++) chain[k] = node_t'(k + 1);
    for (int k = NODES - 2; k > 0; k--) begin
      j        = $urandom_range(0, k);
      t        = chain[k];
      chain[k] = chain[j];
      chain[j] = t;
    end
    push_insert(chain[0], '0);
    for (int k = 1; k < CHAIN_LEN; k++) push_insert(chain[k], chain[k-1]);
    push_query(chain[0], chain[CHAIN_LEN-1]);
    push_query(chain[CHAIN_LEN-1], chain[CHAIN_LEN-2]);
    for (int k = 0; k < CHAIN_PROBE; k++) begin
      i0 = $urandom_range(0, CHAIN_LEN - 1);
      i1 = $urandom_range(0, CHAIN_LEN - 1);
      push_query(chain[i0], chain[i1]);
    end
    push_insert(chain[CHAIN_LEN-1], chain[CHAIN_LEN-1]);
    push_insert(chain[CHAIN_LEN-1], chain[CHAIN_LEN-1]);
    push_query(chain[CHAIN_LEN-1], chain[0]);
    push_query(chain[CHAIN_LEN-1], chain[CHAIN_LEN-2]);
    push_query(chain[CHAIN_LEN-2], chain[CHAIN_LEN-1]);
    for (int k = 0; k < 10; k++) push_query(chain[$urandom_range(0, CHAIN_LEN - 1)], any_node());

    // Final drain; the watchdog ends the run if the block hangs here.
    wait_drained();
    if (expected_ancestors.size() != 0)
      report_mismatch("query left without result", '0, expected_ancestors[0]);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
